FILE: rtl/uvc_payload_frame_assembler_defines.svh
// ----------------------------------------------------------------------------
// UVC payload frame assembler assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UVC_PAYLOAD_FRAME_ASSEMBLER_DEFINES_SVH
`define UVC_PAYLOAD_FRAME_ASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define UPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define UPFA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UPFA_ASSERT(lbl, prop, msg)
`define UPFA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/upfa_pkg.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler package
// Shared constants and types for the front parser, the queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upfa_pkg;

  localparam int unsigned FRAME_SIZE_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;
  localparam int unsigned COUNT_W             = 24;
  localparam int unsigned STAMP_W             = 32;

  // Bit positions in the payload header info byte.
  localparam int unsigned FID_BIT = 0;
  localparam int unsigned EOF_BIT = 1;
  localparam int unsigned PTS_BIT = 2;
  localparam int unsigned SCR_BIT = 3;
  localparam int unsigned STI_BIT = 5;

  localparam logic [7:0] MIN_HEADER_LEN = 8'd2;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_FRAME = 1'b1
  } upfa_kind_e;

  // One queue entry holds every result that a single input item causes.
  // The optional second result is always a frame end.
  typedef struct packed {
    logic               two;
    upfa_kind_e         r0_kind;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] r0_count;
    logic               r0_still;
    logic [COUNT_W-1:0] r1_count;
    logic               r1_still;
    logic [STAMP_W-1:0] pts;
    logic [STAMP_W-1:0] scr;
  } upfa_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } upfa_qstat_t;

endpackage

FILE: rtl/upfa_front.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler front end
// Parses payload headers byte by byte and queues the results each byte causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upfa_front
  import upfa_pkg::*;
#(
  parameter int unsigned FRAME_SIZE_BITS = FRAME_SIZE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         payload_byte_i,
  input  logic               first_of_payload_i,
  input  logic [15:0]        payload_length_i,
  input  logic               cfg_valid_i,
  input  logic [COUNT_W-1:0] cfg_data_i,
  input  upfa_qstat_t        qstat_i,
  output logic               push_o,
  output upfa_entry_t        entry_o
);

  localparam int unsigned CmpW =
    ((FRAME_SIZE_BITS > COUNT_W) ? FRAME_SIZE_BITS : COUNT_W) + 1;

  logic [COUNT_W-1:0]         capacity_q;
  logic                       frame_id_q, frame_id_d;
  logic                       still_mode_q, still_mode_d;
  logic [15:0]                byte_pos_q, byte_pos_d;
  logic [15:0]                remaining_q, remaining_d;
  logic [7:0]                 hdr_len_q, hdr_len_d;
  logic [7:0]                 hdr_flags_q, hdr_flags_d;
  logic                       dropping_q, dropping_d;
  logic [FRAME_SIZE_BITS-1:0] frame_count_q, frame_count_d;
  logic                       frame_still_q, frame_still_d;
  logic [STAMP_W-1:0]         pts_q, pts_d;
  logic [STAMP_W-1:0]         scr_q, scr_d;
  logic [15:0]                data_len_q, data_len_d;
  logic                       has_data_q, has_data_d;

  logic                       accept;
  logic                       active;
  logic                       info;
  logic                       toggle;
  logic                       data_hit;
  logic                       eof_hit;
  logic [15:0]                pos;
  logic [7:0]                 hl_eff;
  logic [7:0]                 flags_now;
  logic [15:0]                scr_base;
  logic [1:0]                 lane;
  logic [FRAME_SIZE_BITS-1:0] fc_start, fc_mid;
  logic                       fs_start, fs_mid;
  logic [CmpW-1:0]            fill_sum;
  logic [CmpW-1:0]            fcq_wide, fcm_wide;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos       = byte_pos_q + 16'd1;
  assign hl_eff    = (payload_byte_i < MIN_HEADER_LEN) ? MIN_HEADER_LEN : payload_byte_i;
  assign active    = accept && !first_of_payload_i && (remaining_q != 16'd0);
  assign info      = (pos == 16'd1);
  assign flags_now = info ? payload_byte_i : hdr_flags_q;
  assign toggle    = active && info &&
                     ((payload_byte_i[FID_BIT] != frame_id_q) ||
                      (payload_byte_i[STI_BIT] != still_mode_q));
  assign data_hit  = active && !info && (pos >= {8'd0, hdr_len_q}) && !dropping_q;
  assign eof_hit   = active && (remaining_q == 16'd1) && flags_now[EOF_BIT];

  assign fc_start = toggle ? '0 : frame_count_q;
  assign fs_start = toggle ? 1'b0 : frame_still_q;
  assign fs_mid   = (active && info && has_data_q) ? payload_byte_i[STI_BIT] : fs_start;
  assign fc_mid   = data_hit ? fc_start + FRAME_SIZE_BITS'(1) : fc_start;
  assign fill_sum = CmpW'(fc_start) + CmpW'(data_len_q);
  assign fcq_wide = CmpW'(frame_count_q);
  assign fcm_wide = CmpW'(fc_mid);

  // Both stamp fields start on a byte index that is 2 mod 4.
  assign scr_base = hdr_flags_q[PTS_BIT] ? 16'd6 : 16'd2;
  assign lane     = pos[1:0] + 2'd2;

  always_comb begin
    byte_pos_d   = byte_pos_q;
    remaining_d  = remaining_q;
    hdr_len_d    = hdr_len_q;
    hdr_flags_d  = hdr_flags_q;
    dropping_d   = dropping_q;
    frame_id_d   = frame_id_q;
    still_mode_d = still_mode_q;
    pts_d        = pts_q;
    scr_d        = scr_q;
    data_len_d   = data_len_q;
    has_data_d   = has_data_q;
    if (accept && first_of_payload_i) begin
      byte_pos_d  = 16'd0;
      hdr_flags_d = 8'd0;
      dropping_d  = 1'b0;
      remaining_d = (payload_length_i != 16'd0) ? payload_length_i - 16'd1 : 16'd0;
      hdr_len_d   = hl_eff;
      has_data_d  = payload_length_i > {8'd0, hl_eff};
      data_len_d  = payload_length_i - {8'd0, hl_eff};
    end else if (active) begin
      byte_pos_d  = pos;
      remaining_d = remaining_q - 16'd1;
      if (info) begin
        hdr_flags_d  = payload_byte_i;
        frame_id_d   = payload_byte_i[FID_BIT];
        still_mode_d = payload_byte_i[STI_BIT];
        if (has_data_q && (fill_sum > CmpW'(capacity_q))) begin
          dropping_d = 1'b1;
        end
      end else begin
        if (hdr_flags_q[PTS_BIT] && (pos >= 16'd2) && (pos <= 16'd5)) begin
          for (int i = 0; i < 4; i++) begin
            if (lane == 2'(i)) begin
              pts_d[8*i +: 8] = payload_byte_i;
            end
          end
        end
        if (hdr_flags_q[SCR_BIT] && (pos >= scr_base) && (pos <= scr_base + 16'd3)) begin
          for (int i = 0; i < 4; i++) begin
            if (lane == 2'(i)) begin
              scr_d[8*i +: 8] = payload_byte_i;
            end
          end
        end
      end
    end
  end

  assign frame_count_d = eof_hit ? '0 : fc_mid;
  assign frame_still_d = eof_hit ? 1'b0 : fs_mid;

  always_comb begin
    push_o            = toggle || data_hit || eof_hit;
    entry_o.two       = (toggle || data_hit) && eof_hit;
    entry_o.r0_kind   = (toggle || !data_hit) ? KIND_FRAME : KIND_DATA;
    entry_o.data_byte = payload_byte_i;
    entry_o.r0_count  = (toggle || data_hit) ? fcq_wide[COUNT_W-1:0] : fcm_wide[COUNT_W-1:0];
    entry_o.r0_still  = toggle ? frame_still_q : fs_mid;
    entry_o.r1_count  = fcm_wide[COUNT_W-1:0];
    entry_o.r1_still  = fs_mid;
    entry_o.pts       = pts_d;
    entry_o.scr       = scr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q    <= '1;
      frame_id_q    <= 1'b0;
      still_mode_q  <= 1'b0;
      byte_pos_q    <= 16'd0;
      remaining_q   <= 16'd0;
      hdr_len_q     <= MIN_HEADER_LEN;
      hdr_flags_q   <= 8'd0;
      dropping_q    <= 1'b0;
      frame_count_q <= '0;
      frame_still_q <= 1'b0;
      pts_q         <= '0;
      scr_q         <= '0;
      data_len_q    <= 16'd0;
      has_data_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      frame_id_q    <= frame_id_d;
      still_mode_q  <= still_mode_d;
      byte_pos_q    <= byte_pos_d;
      remaining_q   <= remaining_d;
      hdr_len_q     <= hdr_len_d;
      hdr_flags_q   <= hdr_flags_d;
      dropping_q    <= dropping_d;
      frame_count_q <= frame_count_d;
      frame_still_q <= frame_still_d;
      pts_q         <= pts_d;
      scr_q         <= scr_d;
      data_len_q    <= data_len_d;
      has_data_q    <= has_data_d;
    end
  end

endmodule

FILE: rtl/upfa_queue.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler queue
// Small first-in first-out buffer of result entries between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uvc_payload_frame_assembler_defines.svh"

module upfa_queue
  import upfa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  upfa_entry_t entry_i,
  input  logic        pop_i,
  output upfa_entry_t head_o,
  output upfa_qstat_t qstat_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  upfa_entry_t     slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign qstat_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign head_o        = slots_q[rd_ptr_q];

  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `UPFA_ASSERT_NEVER(a_no_push_full, push_i && qstat_o.full, "queue written while full")
  `UPFA_ASSERT_NEVER(a_no_pop_empty, pop_i && qstat_o.empty, "queue read while empty")
  `UPFA_ASSERT(a_ptr_count, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers differ when empty")

endmodule

FILE: rtl/upfa_back.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler back end
// Unpacks queued entries into single results held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uvc_payload_frame_assembler_defines.svh"

module upfa_back
  import upfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upfa_entry_t        head_i,
  input  upfa_qstat_t        qstat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic [7:0]         data_byte_o,
  output logic [COUNT_W-1:0] write_offset_o,
  output logic [COUNT_W-1:0] frame_bytes_o,
  output logic               frame_still_o,
  output logic [STAMP_W-1:0] presentation_stamp_o,
  output logic [STAMP_W-1:0] clock_reference_o,
  output logic               last_result_o
);

  logic               valid_q, valid_d;
  logic               phase_q, phase_d;
  upfa_kind_e         kind_q;
  logic [7:0]         data_q;
  logic [COUNT_W-1:0] offset_q;
  logic [COUNT_W-1:0] bytes_q;
  logic               still_q;
  logic [STAMP_W-1:0] pts_q;
  logic [STAMP_W-1:0] scr_q;
  logic               last_q;
  logic               load;

  // A new result enters whenever the queue holds an entry and the output register is free or is being taken.
  assign load  = !qstat_i.empty && (!valid_q || !out_stall_i);
  assign pop_o = load && (phase_q || !head_i.two);

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = !phase_q && head_i.two;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pts_q  <= head_i.pts;
      scr_q  <= head_i.scr;
      last_q <= phase_q || !head_i.two;
      if (phase_q) begin
        kind_q   <= KIND_FRAME;
        data_q   <= 8'd0;
        offset_q <= '0;
        bytes_q  <= head_i.r1_count;
        still_q  <= head_i.r1_still;
      end else if (head_i.r0_kind == KIND_DATA) begin
        kind_q   <= KIND_DATA;
        data_q   <= head_i.data_byte;
        offset_q <= head_i.r0_count;
        bytes_q  <= '0;
        still_q  <= 1'b0;
      end else begin
        kind_q   <= KIND_FRAME;
        data_q   <= 8'd0;
        offset_q <= '0;
        bytes_q  <= head_i.r0_count;
        still_q  <= head_i.r0_still;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  assign out_valid_o          = valid_q;
  assign result_kind_o        = kind_q;
  assign data_byte_o          = data_q;
  assign write_offset_o       = offset_q;
  assign frame_bytes_o        = bytes_q;
  assign frame_still_o        = still_q;
  assign presentation_stamp_o = pts_q;
  assign clock_reference_o    = scr_q;
  assign last_result_o        = last_q;

  `UPFA_ASSERT(a_phase_has_entry, phase_q |-> !qstat_i.empty, "second result without entry")
  `UPFA_ASSERT(a_pair_follows, (valid_q && !last_q) |=> valid_q, "paired result went missing")
  `UPFA_ASSERT(a_second_is_end, (load && phase_q) |=> (kind_q == KIND_FRAME), "second result not frame end")

endmodule

FILE: rtl/uvc_payload_frame_assembler.sv
// ----------------------------------------------------------------------------
// UVC payload frame assembler
// Splits USB video payloads into frame data bytes and frame-complete events.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                 Content
// in       in   in_valid_i / in_stall_o   payload byte, first flag, length
// out      out  out_valid_o / out_stall_i one data byte or one frame end
// cfg      in   cfg_valid_i / cfg_ready_o frame capacity
//
// One input item is taken every cycle while the result queue has room.
// Results leave one per cycle while the output is not stalled; a byte that ends a
// frame can cause two results, which then leave one after the other. An accepted
// item's results are written into the queue and then loaded into the output register.
// Reset clears all parser state at once; there is no clearing pass.
// The input stalls only while the queue between parser and output is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvc_payload_frame_assembler
  import upfa_pkg::*;
#(
  parameter int unsigned FRAME_SIZE_BITS = FRAME_SIZE_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         payload_byte_i,
  input  logic               first_of_payload_i,
  input  logic [15:0]        payload_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic [7:0]         data_byte_o,
  output logic [COUNT_W-1:0] write_offset_o,
  output logic [COUNT_W-1:0] frame_bytes_o,
  output logic               frame_still_o,
  output logic [STAMP_W-1:0] presentation_stamp_o,
  output logic [STAMP_W-1:0] clock_reference_o,
  output logic               last_result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i
);

  upfa_entry_t push_entry;
  upfa_entry_t head_entry;
  upfa_qstat_t qstat;
  logic        push;
  logic        pop;

  assign cfg_ready_o = 1'b1;

  upfa_front #(
    .FRAME_SIZE_BITS(FRAME_SIZE_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .payload_byte_i,
    .first_of_payload_i,
    .payload_length_i,
    .cfg_valid_i,
    .cfg_data_i,
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  upfa_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .qstat_o (qstat)
  );

  upfa_back u_back (
    .clk_i,
    .rst_ni,
    .head_i  (head_entry),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .result_kind_o,
    .data_byte_o,
    .write_offset_o,
    .frame_bytes_o,
    .frame_still_o,
    .presentation_stamp_o,
    .clock_reference_o,
    .last_result_o
  );

endmodule

FILE: tb/sv/upfa_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UVC frame assembly checker
// Watches the payload, result and capacity channels of the frame assembler,
// predicts the data bytes and frame-complete events of every accepted item,
// and compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module upfa_frame_checker
  import upfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         payload_byte_i,
  input  logic               first_of_payload_i,
  input  logic [15:0]        payload_length_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               result_kind_i,
  input  logic [7:0]         data_byte_i,
  input  logic [COUNT_W-1:0] write_offset_i,
  input  logic [COUNT_W-1:0] frame_bytes_i,
  input  logic               frame_still_i,
  input  logic [STAMP_W-1:0] presentation_stamp_i,
  input  logic [STAMP_W-1:0] clock_reference_i,
  input  logic               last_result_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [COUNT_W-1:0] cfg_data_i,
  output int                 mismatch_count_o,
  output int                 results_pending_o,
  output int                 data_checked_o,
  output int                 frames_checked_o
);

  typedef struct {
    upfa_kind_e         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] offset;
    logic [COUNT_W-1:0] bytes;
    logic               still;
    logic [STAMP_W-1:0] pts;
    logic [STAMP_W-1:0] scr;
    logic               last;
  } assembled_t;

  assembled_t         assembled_q[$];

  logic [COUNT_W-1:0] capacity;
  logic               cur_fid;
  logic               cur_still_mode;
  logic [15:0]        pos_in_payload;
  logic [15:0]        bytes_left;
  logic [7:0]         hdr_len;
  logic [7:0]         info_flags;
  logic               drop_payload;
  logic [COUNT_W-1:0] frame_fill;
  logic               fill_is_still;
  logic [STAMP_W-1:0] pts_word;
  logic [STAMP_W-1:0] scr_word;

  function automatic logic [31:0] with_byte(logic [31:0] word, int idx, logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[idx*8 +: 8] = b;
    return w;
  endfunction

  task automatic push_result(upfa_kind_e kind, logic [7:0] data, logic [COUNT_W-1:0] offset,
                             logic [COUNT_W-1:0] bytes, logic still);
    assembled_t r;
    r.kind   = kind;
    r.data   = data;
    r.offset = offset;
    r.bytes  = bytes;
    r.still  = still;
    r.pts    = pts_word;
    r.scr    = scr_word;
    r.last   = 1'b0;
    assembled_q.push_back(r);
  endtask

  task automatic close_frame();
    push_result(KIND_FRAME, 8'h00, '0, frame_fill, fill_is_still);
    frame_fill    = '0;
    fill_is_still = 1'b0;
  endtask

  task automatic parse_byte(logic [7:0] b, logic first, logic [15:0] len);
    int          queued_before;
    int          pos;
    int          total;
    int          scr_base;
    logic [15:0] prior;
    assembled_t  tail;
    if (first) begin
      pos_in_payload = '0;
      info_flags     = '0;
      drop_payload   = 1'b0;
      bytes_left     = (len != 0) ? len - 16'd1 : 16'd0;
      hdr_len        = (b < MIN_HEADER_LEN) ? MIN_HEADER_LEN : b;
    end else if (bytes_left != 0) begin
      queued_before  = assembled_q.size();
      prior          = bytes_left;
      pos_in_payload = pos_in_payload + 16'd1;
      bytes_left     = prior - 16'd1;
      pos            = pos_in_payload;
      if (pos == 1) begin
        total      = prior + 1;
        info_flags = b;
        // A change of frame id or of the still bit closes the frame, empty or not.
        if (b[FID_BIT] != cur_fid || b[STI_BIT] != cur_still_mode) begin
          close_frame();
          cur_still_mode = b[STI_BIT];
        end
        cur_fid = b[FID_BIT];
        if (total > hdr_len) begin
          fill_is_still = b[STI_BIT];
          if (frame_fill + (total - hdr_len) > capacity) begin
            drop_payload = 1'b1;
          end
        end
      end else begin
        scr_base = info_flags[PTS_BIT] ? 6 : 2;
        if (info_flags[PTS_BIT] && pos >= 2 && pos <= 5) begin
          pts_word = with_byte(pts_word, pos - 2, b);
        end
        if (info_flags[SCR_BIT] && pos >= scr_base && pos <= scr_base + 3) begin
          scr_word = with_byte(scr_word, pos - scr_base, b);
        end
        if (pos >= hdr_len && !drop_payload) begin
          push_result(KIND_DATA, b, frame_fill, '0, 1'b0);
          frame_fill = frame_fill + 1'b1;
        end
      end
      if (bytes_left == 0 && info_flags[EOF_BIT]) begin
        close_frame();
      end
      if (assembled_q.size() > queued_before) begin
        tail      = assembled_q.pop_back();
        tail.last = 1'b1;
        assembled_q.push_back(tail);
      end
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  task automatic check_result();
    assembled_t want;
    if (assembled_q.size() == 0) begin
      $display("%0t ns: result with nothing expected, actual kind %0d byte 0x%0h bytes %0d",
               $time, result_kind_i, data_byte_i, frame_bytes_i);
      mismatch_count_o++;
    end else begin
      want = assembled_q.pop_front();
      compare_field("result_kind", want.kind, result_kind_i);
      compare_field("data_byte", want.data, data_byte_i);
      compare_field("write_offset", want.offset, write_offset_i);
      compare_field("frame_bytes", want.bytes, frame_bytes_i);
      compare_field("frame_still", want.still, frame_still_i);
      compare_field("presentation_stamp", want.pts, presentation_stamp_i);
      compare_field("clock_reference", want.scr, clock_reference_i);
      compare_field("last_result", want.last, last_result_i);
      if (want.kind == KIND_DATA) begin
        data_checked_o++;
      end else begin
        frames_checked_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assembled_q.delete();
      capacity          = '1;
      cur_fid           = 1'b0;
      cur_still_mode    = 1'b0;
      pos_in_payload    = '0;
      bytes_left        = '0;
      hdr_len           = MIN_HEADER_LEN;
      info_flags        = '0;
      drop_payload      = 1'b0;
      frame_fill        = '0;
      fill_is_still     = 1'b0;
      pts_word          = '0;
      scr_word          = '0;
      mismatch_count_o  = 0;
      results_pending_o = 0;
      data_checked_o    = 0;
      frames_checked_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(payload_byte_i, first_of_payload_i, payload_length_i);
      end
      results_pending_o = assembled_q.size();
    end
  end

endmodule

FILE: tb/sv/uvc_payload_frame_assembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UVC payload frame assembler testbench
// Streams directed and random USB video payloads into the assembler under
// several frame capacities, with bursty input and a varying output stall,
// and reports the verdict of the frame checker that sits beside the block.
// ----------------------------------------------------------------------------
module uvc_payload_frame_assembler_tb;
  import upfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_ITEMS    = 130;

  localparam logic [7:0] INFO_FID = 8'b1 << FID_BIT;
  localparam logic [7:0] INFO_EOF = 8'b1 << EOF_BIT;
  localparam logic [7:0] INFO_PTS = 8'b1 << PTS_BIT;
  localparam logic [7:0] INFO_SCR = 8'b1 << SCR_BIT;
  localparam logic [7:0] INFO_STI = 8'b1 << STI_BIT;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic               clk_i              = 1'b0;
  logic               rst_ni;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [7:0]         payload_byte       = '0;
  logic               first_of_payload   = 1'b0;
  logic [15:0]        payload_length     = '0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic               result_kind;
  logic [7:0]         data_byte;
  logic [COUNT_W-1:0] write_offset;
  logic [COUNT_W-1:0] frame_bytes;
  logic               frame_still;
  logic [STAMP_W-1:0] presentation_stamp;
  logic [STAMP_W-1:0] clock_reference;
  logic               last_result;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data           = '0;

  int                 mismatches;
  int                 results_pending;
  int                 data_checked;
  int                 frames_checked;

  int                 items_sent         = 0;
  int                 settings_used      = 0;
  int                 burst_left         = 10;
  int                 idle_cycles        = 0;
  logic               stream_fid         = 1'b0;
  logic               stream_sti         = 1'b0;

  stall_mode_e        stall_mode         = STALL_NONE;
  int                 stall_mode_left    = 0;
  int unsigned        stall_phase        = 0;

  logic [COUNT_W-1:0] capacities[6];

  uvc_payload_frame_assembler u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .payload_byte_i      (payload_byte),
    .first_of_payload_i  (first_of_payload),
    .payload_length_i    (payload_length),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .result_kind_o       (result_kind),
    .data_byte_o         (data_byte),
    .write_offset_o      (write_offset),
    .frame_bytes_o       (frame_bytes),
    .frame_still_o       (frame_still),
    .presentation_stamp_o(presentation_stamp),
    .clock_reference_o   (clock_reference),
    .last_result_o       (last_result),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_data_i          (cfg_data)
  );

  upfa_frame_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .payload_byte_i      (payload_byte),
    .first_of_payload_i  (first_of_payload),
    .payload_length_i    (payload_length),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .result_kind_i       (result_kind),
    .data_byte_i         (data_byte),
    .write_offset_i      (write_offset),
    .frame_bytes_i       (frame_bytes),
    .frame_still_i       (frame_still),
    .presentation_stamp_i(presentation_stamp),
    .clock_reference_i   (clock_reference),
    .last_result_i       (last_result),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_data_i          (cfg_data),
    .mismatch_count_o    (mismatches),
    .results_pending_o   (results_pending),
    .data_checked_o      (data_checked),
    .frames_checked_o    (frames_checked)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // The result side switches between stall patterns, each held for a random stretch.
  always @(negedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= stall_mode_e'($urandom_range(0, 3));
      stall_mode_left <= $urandom_range(40, 300);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= ((stall_phase % 13) < 5);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first, input logic [15:0] len);
    in_valid         <= 1'b1;
    payload_byte     <= b;
    first_of_payload <= first;
    payload_length   <= len;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
  endtask

  // Sends the first count bytes of a payload: header length byte, info byte, then
  // random bytes. A count beyond the length leaves stray bytes behind it.
  task automatic send_payload(input logic [15:0] plen, input logic [7:0] hlen,
                              input logic [7:0] info, input int count);
    send_item(hlen, 1'b1, plen);
    for (int i = 1; i < count; i++) begin
      send_item((i == 1) ? info : 8'($urandom), 1'b0, 16'($urandom));
    end
  endtask

  task automatic send_random_payload();
    logic [15:0] plen;
    logic [7:0]  hlen;
    logic [7:0]  info;
    int          count;
    int          pick;
    pick = $urandom_range(0, 19);
    info = 8'($urandom);
    // Frame id and still bit mostly hold, so frames span several payloads.
    info[FID_BIT] = ($urandom_range(0, 3) == 0) ? !stream_fid : stream_fid;
    info[STI_BIT] = ($urandom_range(0, 7) == 0) ? !stream_sti : stream_sti;
    info[EOF_BIT] = ($urandom_range(0, 2) == 0);
    stream_fid = info[FID_BIT];
    stream_sti = info[STI_BIT];
    hlen  = 8'(2 + (info[PTS_BIT] ? 4 : 0) + (info[SCR_BIT] ? 6 : 0));
    plen  = 16'(hlen + $urandom_range(0, 20));
    count = plen;
    case (pick)
      0: hlen = 8'($urandom_range(0, 16));
      1: count = $urandom_range(1, plen);
      2: count = plen + $urandom_range(1, 3);
      3: begin
        plen  = 16'($urandom_range(0, 1));
        count = $urandom_range(1, 2);
      end
      4: begin
        plen  = 16'($urandom_range(60, 65535));
        count = $urandom_range(2, 40);
      end
      5: begin
        plen  = 16'(hlen + $urandom_range(30, 70));
        count = plen;
      end
      default: ;
    endcase
    send_payload(plen, hlen, info, count);
  endtask

  // Lets every outstanding result and any item still in flight drain out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int phase_start;
    rst_ni = 1'b0;
    capacities[0] = '1;
    capacities[1] = 24'd17;
    capacities[2] = 24'd1;
    capacities[3] = 24'd64;
    capacities[4] = 24'($urandom_range(2, 300));
    capacities[5] = '1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: tiny payloads, a stray byte, a short header, a header longer
    // than its payload, a restart inside a huge payload and a still toggle.
    send_payload(16'd0, 8'h00, 8'h00, 1);
    send_payload(16'd1, 8'hFF, 8'h00, 1);
    send_item(8'hA5, 1'b0, 16'hFFFF);
    send_payload(16'd4, 8'h00, INFO_FID | INFO_EOF, 4);
    send_payload(16'd3, 8'd12, INFO_PTS | INFO_SCR, 3);
    send_payload(16'hFFFF, 8'hFF, INFO_FID | INFO_PTS | INFO_SCR | INFO_STI, 6);
    send_payload(16'd5, 8'd2, INFO_FID | INFO_EOF, 5);
    // With no capacity left the payload is dropped, yet EOF still ends the frame.
    settle();
    write_capacity('0);
    send_payload(16'd4, 8'd2, INFO_FID | INFO_EOF, 4);

    foreach (capacities[i]) begin
      settle();
      write_capacity(capacities[i]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_random_payload();
      end
    end

    settle();
    $display("Sent %0d payload bytes under %0d capacity settings.", items_sent, settings_used);
    $display("Checked %0d data bytes and %0d frame ends.", data_checked, frames_checked);
    if (mismatches == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      if (results_pending != 0) begin
        $display("%0d expected results never arrived", results_pending);
      end
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/upfa_pkg.sv
rtl/upfa_front.sv
rtl/upfa_queue.sv
rtl/upfa_back.sv
rtl/uvc_payload_frame_assembler.sv
tb/sv/upfa_frame_checker.sv
tb/sv/uvc_payload_frame_assembler_tb.sv
